[rtl/aes_pkg.sv]
package aes_pkg;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out_item;

    localparam int unsigned NumRounds = 14;

    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_reg_idx;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tbl[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] t);
        return {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

[rtl/aes256_block_encrypt.sv]
// channel | signals                         | item
// in      | i_in_valid / o_in_ready / i_in   | plaintext block
// out     | o_out_valid / i_out_ready / o_out| ciphertext block
// cfg     | i_cfg_we / i_cfg_idx / i_cfg_data| key word, no handshake
// One block per cycle while the output is not stalled and no key write is pending; an item
// moves through r_st[0..14] to o_out (15 stages: initial key XOR, then one round per stage).
// Round keys come from an 8-stage registered schedule, two round keys per stage; it stays
// ahead of every item accepted after o_in_ready rises again following a key write.
// o_in_ready is low during a key write, the cycle after it and the first cycle after reset.
// Reset clears the key and all valid bits. A stall at the output holds the whole pipe.
module aes256_block_encrypt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  aes_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output aes_pkg::t_out_item o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);

    localparam int unsigned NumSt = aes_pkg::NumRounds + 1;

    logic [63:0]  r_key [4];
    logic [127:0] rk [15];
    logic [127:0] r_st [NumSt];
    logic         r_vld [NumSt];
    logic [127:0] n_st [NumSt];
    logic         adv;
    logic         r_cfg_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
        end else if (i_cfg_we) begin
            unique case (aes_pkg::t_reg_idx'(i_cfg_idx))
                aes_pkg::REG_KEY0: r_key[0] <= i_cfg_data;
                aes_pkg::REG_KEY1: r_key[1] <= i_cfg_data;
                aes_pkg::REG_KEY2: r_key[2] <= i_cfg_data;
                aes_pkg::REG_KEY3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // first round key is registered from the key registers and updates in the cycle after them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_busy <= 1'b1;
        end else begin
            r_cfg_busy <= i_cfg_we;
        end
    end

    aes_key_sched u_ks (
        .i_clk (i_clk),
        .i_key ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .o_rk  (rk)
    );

    assign adv = !r_vld[NumSt-1] || i_out_ready;
    assign o_in_ready = adv && !i_cfg_we && !r_cfg_busy;

    assign n_st[0] = i_in ^ rk[0];
    for (genvar r = 1; r < NumSt; r++) begin : g_rnd
        aes_round #(.LAST(r == NumSt - 1)) u_rnd (
            .i_state (r_st[r-1]),
            .i_rk    (rk[r]),
            .o_state (n_st[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumSt; k++) r_vld[k] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_in_valid && o_in_ready;
            for (int k = 1; k < NumSt; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NumSt; k++) r_st[k] <= n_st[k];
        end
    end

    assign o_out_valid = r_vld[NumSt-1];
    assign o_out       = r_st[NumSt-1];

endmodule

[rtl/aes_key_sched.sv]
// Round key schedule, two 128-bit round keys per stage of the key registers.
// Held static between blocks; recomputed as a registered chain, one 8-word step a cycle.
module aes_key_sched (
    input  logic         i_clk,
    input  logic [255:0] i_key,
    output logic [127:0] o_rk [15]
);

    // w8[j] = words 8j .. 8j+7 of the schedule
    logic [255:0] r_w8 [8];

    always_ff @(posedge i_clk) begin
        r_w8[0] <= i_key;
    end

    for (genvar j = 1; j < 8; j++) begin : g_step
        logic [255:0] n_w;
        logic [7:0]   rc;
        always_comb begin
            logic [31:0] t;
            logic [31:0] w [8];
            for (int k = 0; k < 8; k++) w[k] = r_w8[j-1][255-32*k -: 32];
            rc = 8'(8'h01 << (j - 1));
            t = r_w8[j-1][31:0];
            w[0] = w[0] ^ aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            for (int k = 1; k < 8; k++) begin
                if (k == 4) w[k] = w[k] ^ aes_pkg::sub_word(w[k-1]);
                else        w[k] = w[k] ^ w[k-1];
            end
            n_w = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
        end
        always_ff @(posedge i_clk) begin
            r_w8[j] <= n_w;
        end
    end

    for (genvar r = 0; r < 15; r++) begin : g_out
        assign o_rk[r] = (r % 2 == 0) ? r_w8[r/2][255:128] : r_w8[r/2][127:0];
    end

endmodule

[rtl/aes_round.sv]
// One cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_round #(
    parameter bit LAST = 1'b0
) (
    input  logic [127:0] i_state,
    input  logic [127:0] i_rk,
    output logic [127:0] o_state
);

    always_comb begin
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        for (int i = 0; i < 16; i++) s[i] = i_state[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4*c] = aes_pkg::sbox(s[r + 4*((c + r) % 4)]);
        if (!LAST) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ aes_pkg::xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ aes_pkg::xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ aes_pkg::xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ aes_pkg::xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) o_state[127-8*i -: 8] = t[i] ^ i_rk[127-8*i -: 8];
    end

endmodule

[tb/aes256_block_encrypt_tb.sv]
`timescale 1ns / 100ps

module aes256_block_encrypt_tb;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    aes_pkg::t_in_item  i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    aes_pkg::t_out_item o_out;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [63:0]        i_cfg_data;

    aes256_block_encrypt u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    aes_pkg::t_in_item  plain_q[$];
    aes_pkg::t_out_item cipher_q[$];
    logic [63:0] key_regs[4];
    logic [7:0]  sub_tbl[256];
    int          err_cnt;
    int          blocks_in;
    int          blocks_out;
    int          key_sets;
    bit          quiet_mode;
    bit          in_taken;
    int          in_gap;
    int          out_hold;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // GF(2^8) multiply, AES polynomial
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // S-box from its definition: inverse (a^254) then affine map
    function automatic logic [7:0] sbox_calc(input logic [7:0] a);
        logic [7:0] inv;
        logic [7:0] sq;
        inv = 8'h01;
        sq  = a;
        for (int k = 0; k < 8; k++) begin
            if (k != 0) inv = gf_mul(inv, sq);
            sq = gf_mul(sq, sq);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                   ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [31:0] sub_bytes32(input logic [31:0] t);
        return {sub_tbl[t[31:24]], sub_tbl[t[23:16]], sub_tbl[t[15:8]], sub_tbl[t[7:0]]};
    endfunction

    function automatic aes_pkg::t_out_item aes256_encrypt(input aes_pkg::t_in_item blk);
        logic [31:0] w[60];
        logic [7:0]  st[16];
        logic [7:0]  tmp[16];
        logic [31:0] t;
        logic [7:0]  rcon;
        logic [127:0] flat;
        aes_pkg::t_out_item res;
        rcon = 8'h01;
        for (int i = 0; i < 4; i++) begin
            w[2*i]   = key_regs[i][63:32];
            w[2*i+1] = key_regs[i][31:0];
        end
        for (int i = 8; i < 60; i++) begin
            t = w[i-1];
            if (i % 8 == 0) begin
                t = sub_bytes32({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = {rcon[6:0], 1'b0};
            end else if (i % 8 == 4) begin
                t = sub_bytes32(t);
            end
            w[i] = w[i-8] ^ t;
        end
        flat = blk;
        for (int i = 0; i < 16; i++) st[i] = flat[127-8*i -: 8];
        for (int rnd = 0; rnd <= 14; rnd++) begin
            if (rnd != 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[r+4*c] = sub_tbl[st[r+4*((c+r)%4)]];
                if (rnd != 14) begin
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++)
                            st[r+4*c] = gf_mul(tmp[r+4*c], 8'h02)
                                ^ gf_mul(tmp[(r+1)%4+4*c], 8'h03)
                                ^ tmp[(r+2)%4+4*c] ^ tmp[(r+3)%4+4*c];
                end else begin
                    st = tmp;
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[r+4*c] ^= w[4*rnd+c][31-8*r -: 8];
        end
        for (int i = 0; i < 16; i++) flat[127-8*i -: 8] = st[i];
        res = flat;
        return res;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input driver
    always @(negedge i_clk) begin
        bit nv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            nv = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (plain_q.size() > 0) begin
                i_in <= plain_q.pop_front();
                nv = 1'b1;
                in_gap = idle_len();
            end
            i_in_valid <= nv;
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n || out_hold == 0) begin
            i_out_ready <= 1'b1;
            if (i_rst_n) out_hold = idle_len();
        end else begin
            i_out_ready <= 1'b0;
            out_hold--;
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        aes_pkg::t_out_item exp_blk;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                cipher_q.push_back(aes256_encrypt(i_in));
                blocks_in++;
            end
            if (o_out_valid && i_out_ready) begin
                blocks_out++;
                if (cipher_q.size() == 0) begin
                    $error("unexpected ciphertext %h", o_out);
                    err_cnt++;
                end else begin
                    exp_blk = cipher_q.pop_front();
                    if (o_out.cipher_high !== exp_blk.cipher_high) begin
                        $error("cipher_high expected %h actual %h",
                               exp_blk.cipher_high, o_out.cipher_high);
                        err_cnt++;
                    end
                    if (o_out.cipher_low !== exp_blk.cipher_low) begin
                        $error("cipher_low expected %h actual %h",
                               exp_blk.cipher_low, o_out.cipher_low);
                        err_cnt++;
                    end
                end
            end
        end
    end

    task automatic drive_key(input aes_pkg::t_reg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        key_regs[idx] = val;
    endtask

    task automatic load_key(input logic [255:0] k);
        drive_key(aes_pkg::REG_KEY0, k[255:192]);
        drive_key(aes_pkg::REG_KEY1, k[191:128]);
        drive_key(aes_pkg::REG_KEY2, k[127:64]);
        drive_key(aes_pkg::REG_KEY3, k[63:0]);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        key_sets++;
    endtask

    // items may follow a key write at once; the block holds them off itself
    task automatic settle_key();
        repeat (1) @(posedge i_clk);
    endtask

    task automatic drain();
        while (plain_q.size() > 0 || i_in_valid || cipher_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic aes_pkg::t_in_item rand_block();
        aes_pkg::t_in_item b;
        case ($urandom_range(0, 9))
            0: b = '0;
            1: b = '1;
            2: b = {rand64(), 64'h0};
            3: b = {64'hffff_ffff_ffff_ffff, rand64()};
            default: b = {rand64(), rand64()};
        endcase
        return b;
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) plain_q.push_back(rand_block());
    endtask

    initial begin
        for (int i = 0; i < 256; i++) sub_tbl[i] = sbox_calc(8'(i));
        for (int i = 0; i < 4; i++) key_regs[i] = '0;
        err_cnt    = 0;
        blocks_in  = 0;
        blocks_out = 0;
        key_sets   = 0;
        quiet_mode = 1'b0;
        in_taken   = 1'b0;
        out_hold   = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        i_out_ready = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = aes_pkg::REG_KEY0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        settle_key();

        // reset key (all zero), directed blocks
        plain_q.push_back('0);
        plain_q.push_back('1);
        plain_q.push_back({64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff});
        plain_q.push_back({64'h8000_0000_0000_0000, 64'h0});
        plain_q.push_back({64'h0, 64'h0000_0000_0000_0001});
        plain_q.push_back({64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa});
        plain_q.push_back({64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555});
        plain_q.push_back({64'hffff_ffff_ffff_ffff, 64'h0});
        drain();

        // standard test key
        load_key(256'h0001_0203_0405_0607_0809_0a0b_0c0d_0e0f_1011_1213_1415_1617_1819_1a1b_1c1d_1e1f);
        settle_key();
        plain_q.push_back({64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff});
        plain_q.push_back('0);
        plain_q.push_back('1);
        drain();

        load_key('1);
        settle_key();
        plain_q.push_back('0);
        plain_q.push_back('1);
        plain_q.push_back({64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555});
        queue_random(150);
        drain();

        load_key({4{64'haaaa_aaaa_aaaa_aaaa}});
        settle_key();
        queue_random(150);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            quiet_mode = (ph == 2);
            load_key({rand64(), rand64(), rand64(), rand64()});
            settle_key();
            queue_random(150);
            drain();
        end

        // single register rewrite keeps the others
        quiet_mode = 1'b0;
        drive_key(aes_pkg::REG_KEY2, 64'h0);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        key_sets++;
        settle_key();
        queue_random(40);
        drain();

        $display("Encrypted %0d blocks under %0d keys, %0d ciphertexts checked.",
                 blocks_in, key_sets + 1, blocks_out);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d ciphertexts pending.", cipher_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
rtl/aes_pkg.sv
rtl/aes_key_sched.sv
rtl/aes_round.sv
rtl/aes256_block_encrypt.sv
tb/aes256_block_encrypt_tb.sv
